// ===== src/ring_buffer_fifo_defines.svh =====
// ============================================================================
// Ring buffer FIFO assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ============================================================================
`ifndef RING_BUFFER_FIFO_DEFINES_SVH
`define RING_BUFFER_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock, off during reset.
`define RBF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ring_buffer_fifo: assertion failed");
// Next-cycle implication, sampled on the rising clock, off during reset.
`define RBF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ring_buffer_fifo: assertion failed");
`else
`define RBF_ASSERT_IMP(label, ante, cons)
`define RBF_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== src/rbf_pkg.sv =====
// ============================================================================
// Ring buffer FIFO package
// Command codes, status codes, fixed field widths and the result struct.
// ============================================================================
package rbf_pkg;

  // Fixed widths of the capacity register, run length, occupancy and command fields.
  localparam int CAP_W  = 7;
  localparam int RUN_W  = 7;
  localparam int OCC_W  = 7;
  localparam int CMD_W  = 3;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUT_RUN = 3'd4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Per-item outcome handed from the controller to the output stage.
  typedef struct packed {
    status_t          status;
    logic             rd_ok;
    logic [OCC_W-1:0] occupancy;
  } rbf_res_t;

endpackage

// ===== src/rbf_mem.sv =====
// ============================================================================
// Ring buffer FIFO store
// Single write port and one registered read port with write-through bypass,
// so the head word is always ready for the controller.
// ============================================================================
module rbf_mem
  import rbf_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [AW-1:0]         raddr,
  output logic [DATA_WIDTH-1:0] head
);

  logic [DATA_WIDTH-1:0] mem_r [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [DATA_WIDTH-1:0] byp_data_r;
  logic                  byp_r;

  // Storage array with a registered read of the next head address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  // A write to the address being read this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= we && (waddr == raddr);
    end
    byp_data_r <= wdata;
  end

  assign head = byp_r ? byp_data_r : rdata_r;

endmodule

// ===== src/rbf_ctrl.sv =====
// ============================================================================
// Ring buffer FIFO controller
// Holds capacity, pointers, entry count and run state, and decodes one
// command per cycle, when stepped, into state updates, a store write and a result.
// ============================================================================
module rbf_ctrl
  import rbf_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int PW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [CMD_W-1:0] command,
  input  logic [RUN_W-1:0] run_length,
  input  logic             cfg_wr,
  input  logic [CAP_W-1:0] cfg_capacity,
  output logic             mem_we,
  output logic [PW-1:0]    mem_waddr,
  output logic [PW-1:0]    mem_raddr,
  output rbf_res_t         res
);

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [RUN_W-1:0] run_rem_r, run_rem_nxt;
  logic             run_rej_r, run_rej_nxt;

  logic [CW-1:0]    eff_cap;
  logic [CW-1:0]    rd_inc, wr_inc;
  logic [PW-1:0]    rd_adv, wr_adv;
  logic             full_c;
  logic [RUN_W-1:0] run_len;
  logic             run_over;
  logic [RUN_W-1:0] rem_cur;
  logic             rej_cur;

  // Capacity saturates at the built depth.
  assign eff_cap = (32'(cap_r) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cap_r);

  // Pointer advance with wrap at the capacity.
  assign rd_inc = CW'(rd_ptr_r) + CW'(1);
  assign wr_inc = CW'(wr_ptr_r) + CW'(1);
  assign rd_adv = (rd_inc >= eff_cap) ? '0 : PW'(rd_inc);
  assign wr_adv = (wr_inc >= eff_cap) ? '0 : PW'(wr_inc);

  assign full_c = (count_r >= eff_cap);

  // Run start: a zero length counts as one, reject if it cannot all fit.
  assign run_len  = (run_length == '0) ? RUN_W'(1) : run_length;
  assign run_over = (32'(count_r) + 32'(run_len)) > 32'(eff_cap);
  assign rem_cur  = (run_rem_r == '0) ? run_len : run_rem_r;
  assign rej_cur  = (run_rem_r == '0) ? run_over : run_rej_r;

  // Command decode and next-state logic.
  always_comb begin
    cap_nxt     = cap_r;
    rd_ptr_nxt  = rd_ptr_r;
    wr_ptr_nxt  = wr_ptr_r;
    count_nxt   = count_r;
    run_rem_nxt = run_rem_r;
    run_rej_nxt = run_rej_r;
    mem_we      = 1'b0;
    res.status  = ST_OK;
    res.rd_ok   = 1'b0;
    if (cfg_wr) begin
      cap_nxt     = cfg_capacity;
      rd_ptr_nxt  = '0;
      wr_ptr_nxt  = '0;
      count_nxt   = '0;
      run_rem_nxt = '0;
      run_rej_nxt = 1'b0;
    end else if (step) begin
      if (command != CMD_PUT_RUN) begin
        run_rem_nxt = '0;
        run_rej_nxt = 1'b0;
      end
      unique case (command) inside
        CMD_PUT: begin
          if (full_c) begin
            res.status = ST_FULL;
          end else begin
            mem_we     = 1'b1;
            wr_ptr_nxt = wr_adv;
            count_nxt  = count_r + CW'(1);
          end
        end
        CMD_GET, CMD_PEEK: begin
          if (count_r == '0) begin
            res.status = ST_EMPTY;
          end else begin
            res.rd_ok = 1'b1;
            if (command == CMD_GET) begin
              rd_ptr_nxt = rd_adv;
              count_nxt  = count_r - CW'(1);
            end
          end
        end
        CMD_CLEAR: begin
          rd_ptr_nxt = '0;
          wr_ptr_nxt = '0;
          count_nxt  = '0;
        end
        CMD_PUT_RUN: begin
          run_rem_nxt = rem_cur - RUN_W'(1);
          run_rej_nxt = (run_rem_nxt == '0) ? 1'b0 : rej_cur;
          if (rej_cur || full_c) begin
            res.status = ST_FULL;
          end else begin
            mem_we     = 1'b1;
            wr_ptr_nxt = wr_adv;
            count_nxt  = count_r + CW'(1);
          end
        end
        default: begin
          // Unknown command: only the run cancel above applies.
        end
      endcase
    end
    res.occupancy = OCC_W'(count_nxt);
  end

  assign mem_waddr = wr_ptr_r;
  // Read the head for the next cycle; address zero while in reset.
  assign mem_raddr = rst_n ? rd_ptr_nxt : '0;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      count_r   <= '0;
      run_rem_r <= '0;
      run_rej_r <= 1'b0;
    end else begin
      cap_r     <= cap_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      count_r   <= count_nxt;
      run_rem_r <= run_rem_nxt;
      run_rej_r <= run_rej_nxt;
    end
  end

endmodule

// ===== src/ring_buffer_fifo.sv =====
// ============================================================================
// Ring buffer FIFO
// Circular FIFO of data words with a programmable capacity and
// all-or-nothing run writes.
// ============================================================================
// Usage: each input item on the in_ channel is one command (put, get, peek,
// clear or one element of a run) and yields exactly one result item on the
// out_ channel with read data, a status code and the occupancy after it.
// The result of an accepted item shows on out_ in the cycle after it is
// accepted. One item is taken per cycle unless a low out_ready holds the
// result register; the count update and the head word, held in a registered
// read of the store with write bypass, both settle before the next item.
// The cfg_ channel writes the capacity and empties the FIFO; write it only
// while no item is in flight. cfg_ready is always high.
// Reset: synchronous on rst_n low; capacity returns to 64, the FIFO is
// empty and no result is pending. Store contents are not cleared.
// Stall: the result register holds while out_ready is low; in_ready stays
// high as long as the result register is empty or being emptied.
// ============================================================================
`include "ring_buffer_fifo_defines.svh"

module ring_buffer_fifo
  import rbf_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Command channel.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [DATA_WIDTH-1:0] in_data_in,
  input  logic [RUN_W-1:0]      in_run_length,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_read_data,
  output logic [1:0]            out_status,
  output logic [OCC_W-1:0]      out_occupancy,
  // Capacity register write.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CAP_W-1:0]      cfg_capacity
);

  localparam int PW = $clog2(DEPTH);

  logic                  accept;
  logic                  cfg_wr;
  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic [PW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] head;
  rbf_res_t              res;

  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_read_data_r;
  status_t               out_status_r;
  logic [OCC_W-1:0]      out_occupancy_r;

  // Handshakes.
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  rbf_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .command     (in_command),
    .run_length  (in_run_length),
    .cfg_wr      (cfg_wr),
    .cfg_capacity(cfg_capacity),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_raddr   (mem_raddr),
    .res         (res)
  );

  rbf_mem #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(in_data_in),
    .raddr(mem_raddr),
    .head (head)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload; read data is zero unless a read succeeded.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data_r <= res.rd_ok ? head : '0;
      out_status_r    <= res.status;
      out_occupancy_r <= res.occupancy;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  // Every accepted item leaves a result in the output register.
  `RBF_ASSERT_NXT(a_accept_gives_result, accept, out_valid_r)
  // An empty answer only comes from a FIFO holding nothing, with no data.
  `RBF_ASSERT_IMP(a_empty_is_zero, out_valid_r && out_status_r == ST_EMPTY,
                  out_occupancy_r == '0 && out_read_data_r == '0)
  // A rejected write never carries read data.
  `RBF_ASSERT_IMP(a_full_no_data, out_valid_r && out_status_r == ST_FULL,
                  out_read_data_r == '0)

endmodule

// ===== test/tb_ring_buffer_fifo.sv =====
// ============================================================================
// Ring buffer FIFO testbench
// Sends put, get, peek, clear and run commands through the command channel
// and checks every result item against a cycle-free model of the FIFO kept
// here. It covers several capacity settings, including zero and values above
// the built depth. Both channels idle at random, and the result side holds
// off once for a long stretch so that the command side backs up.
// ============================================================================
module tb_ring_buffer_fifo
  import rbf_pkg::*;
();

  localparam int FIFO_DEPTH = 64;
  localparam int WORD_W = 8;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int HOLD_OFF_AT = 400;
  localparam int PHASE_ITEMS = 178;
  localparam int NUM_PHASES = 8;

  // Command codes the block does not define; they only cancel a pending run.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_PUT_RUN + 3'd1;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [WORD_W-1:0] data;
    logic [RUN_W-1:0]  run_length;
  } fifo_cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
  } fifo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic [WORD_W-1:0] in_data_in = '0;
  logic [RUN_W-1:0] in_run_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_W-1:0] out_read_data;
  logic [1:0] out_status;
  logic [OCC_W-1:0] out_occupancy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_W-1:0] cfg_capacity = '0;

  // Model state of the FIFO.
  logic [WORD_W-1:0] fifo_words [FIFO_DEPTH];
  logic [5:0] head_idx;
  logic [5:0] tail_idx;
  logic [6:0] fill;
  logic [6:0] run_left;
  logic run_refused;
  logic [CAP_W-1:0] cap_setting;

  fifo_cmd_t cmd_queue [$];
  fifo_result_t pending_results [$];
  fifo_cmd_t next_cmd;
  fifo_result_t oldest;

  int send_idle_pct = 11;
  int recv_idle_pct = 48;
  int items_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int full_answers = 0;
  int empty_answers = 0;
  int cap_writes = 0;
  int quiet_cycles = 0;
  int hold_off_left = 0;
  bit hold_off_used = 1'b0;
  bit in_taken = 1'b0;

  ring_buffer_fifo #(
    .DEPTH(FIFO_DEPTH),
    .DATA_WIDTH(WORD_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_data_in(in_data_in),
    .in_run_length(in_run_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_read_data(out_read_data),
    .out_status(out_status),
    .out_occupancy(out_occupancy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_capacity(cfg_capacity)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Next pointer position, wrapping at the effective capacity.
  function automatic logic [5:0] wrap_next(input logic [5:0] p, input int lim);
    return (int'(p) + 1 >= lim) ? 6'd0 : p + 6'd1;
  endfunction

  // Stores one word at the tail if there is room.
  function automatic status_t store_word(input logic [WORD_W-1:0] w, input int lim);
    if (int'(fill) >= lim) return ST_FULL;
    fifo_words[tail_idx] = w;
    tail_idx = wrap_next(tail_idx, lim);
    fill = fill + 7'd1;
    return ST_OK;
  endfunction

  // Applies one command to the model and returns the result it should give.
  function automatic fifo_result_t predict_fifo(input fifo_cmd_t c);
    fifo_result_t r;
    int lim;
    int len;
    lim = (int'(cap_setting) > FIFO_DEPTH) ? FIFO_DEPTH : int'(cap_setting);
    r.read_data = '0;
    r.status = ST_OK;
    if (c.command != CMD_PUT_RUN) begin
      run_left = '0;
      run_refused = 1'b0;
    end
    case (c.command) inside
      CMD_PUT: begin
        r.status = store_word(c.data, lim);
      end
      CMD_GET, CMD_PEEK: begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.read_data = fifo_words[head_idx];
          if (c.command == CMD_GET) begin
            head_idx = wrap_next(head_idx, lim);
            fill = fill - 7'd1;
          end
        end
      end
      CMD_CLEAR: begin
        head_idx = '0;
        tail_idx = '0;
        fill = '0;
      end
      CMD_PUT_RUN: begin
        // The first element of a run decides the whole run.
        if (run_left == 0) begin
          len = (c.run_length == 0) ? 1 : int'(c.run_length);
          run_refused = (int'(fill) + len > lim);
          run_left = len[6:0];
        end
        run_left = run_left - 7'd1;
        if (run_refused) r.status = ST_FULL;
        else r.status = store_word(c.data, lim);
        if (run_left == 0) run_refused = 1'b0;
      end
      default: begin
      end
    endcase
    r.occupancy = fill;
    return r;
  endfunction

  // Command driver: offers queued items at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (cmd_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_cmd = cmd_queue.pop_front();
        in_command <= next_cmd.command;
        in_data_in <= next_cmd.data;
        in_run_length <= next_cmd.run_length;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left--;
    end else if (!hold_off_used && items_accepted >= HOLD_OFF_AT) begin
      hold_off_used = 1'b1;
      hold_off_left = HOLD_OFF_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Monitor: updates the model on every handshake and checks results.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst_n) begin
      head_idx = '0;
      tail_idx = '0;
      fill = '0;
      run_left = '0;
      run_refused = 1'b0;
      cap_setting = CAP_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_setting = cfg_capacity;
        head_idx = '0;
        tail_idx = '0;
        fill = '0;
        run_left = '0;
        run_refused = 1'b0;
        cap_writes++;
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        next_cmd.command = in_command;
        next_cmd.data = in_data_in;
        next_cmd.run_length = in_run_length;
        oldest = predict_fifo(next_cmd);
        if (oldest.status == ST_FULL) full_answers++;
        if (oldest.status == ST_EMPTY) empty_answers++;
        pending_results.push_back(oldest);
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result item arrived with no command outstanding");
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          results_checked++;
          if (out_read_data !== oldest.read_data) begin
            $error("read_data: expected %0h, got %0h", oldest.read_data, out_read_data);
            mismatches++;
          end
          if (out_status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_status);
            mismatches++;
          end
          if (out_occupancy !== oldest.occupancy) begin
            $error("occupancy: expected %0d, got %0d", oldest.occupancy, out_occupancy);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when no channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_ring_buffer_fifo: done, errors");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] d,
                           input logic [RUN_W-1:0] rl);
    fifo_cmd_t c;
    c.command = cmd;
    c.data = d;
    c.run_length = rl;
    cmd_queue.push_back(c);
  endtask

  // Random traffic, mostly complete runs, with the share of gets set by get_weight.
  task automatic queue_random_ops(input int n_items, input int get_weight);
    int added;
    int pick;
    int len;
    int emit;
    int i;
    added = 0;
    while (added < n_items) begin
      pick = int'($urandom_range(99, 0));
      if (pick < 25) begin
        queue_cmd(CMD_PUT, WORD_W'($urandom), RUN_W'($urandom));
        added++;
      end else if (pick < 25 + get_weight) begin
        queue_cmd(CMD_GET, WORD_W'($urandom), RUN_W'($urandom));
        added++;
      end else if (pick < 32 + get_weight) begin
        queue_cmd(CMD_PEEK, WORD_W'($urandom), RUN_W'($urandom));
        added++;
      end else if (pick < 35 + get_weight) begin
        queue_cmd(CMD_CLEAR, WORD_W'($urandom), RUN_W'($urandom));
        added++;
      end else if (pick < 38 + get_weight) begin
        queue_cmd(CMD_W'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED)),
                  WORD_W'($urandom), RUN_W'($urandom));
        added++;
      end else begin
        // A run, sometimes cut short so that the next command abandons it.
        pick = int'($urandom_range(99, 0));
        if (pick < 12) len = 0;
        else if (pick < 75) len = int'($urandom_range(8, 1));
        else if (pick < 95) len = int'($urandom_range(64, 9));
        else len = int'($urandom_range(127, 65));
        emit = (len == 0) ? 1 : len;
        if ($urandom_range(99, 0) < 12) emit = int'($urandom_range(emit, 1));
        for (i = 0; i < emit; i++) begin
          queue_cmd(CMD_PUT_RUN, WORD_W'($urandom),
                    (i == 0) ? len[RUN_W-1:0] : RUN_W'($urandom));
          added++;
        end
      end
    end
  endtask

  // Waits until every queued command has been answered.
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [NUM_PHASES];
    int p;
    phase_caps = '{7'd64, 7'd1, 7'd127, 7'd5, 7'd0, 7'd17, 7'd2, 7'd64};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed commands at the reset capacity: empty reads, word extremes,
    // unused codes, run of length zero, run continuation with its length
    // ignored, abandoned run, oversized run, clear.
    queue_cmd(CMD_GET, 8'h00, 7'd0);
    queue_cmd(CMD_PEEK, 8'hFF, 7'd127);
    queue_cmd(CMD_PUT, 8'h00, 7'd0);
    queue_cmd(CMD_PUT, 8'hFF, 7'd127);
    queue_cmd(CMD_PEEK, 8'h00, 7'd0);
    queue_cmd(CMD_GET, 8'h00, 7'd0);
    queue_cmd(CMD_GET, 8'h00, 7'd0);
    queue_cmd(CMD_FIRST_UNUSED, 8'hFF, 7'd127);
    queue_cmd(CMD_LAST_UNUSED, 8'h00, 7'd0);
    queue_cmd(CMD_PUT_RUN, 8'hAA, 7'd0);
    queue_cmd(CMD_PUT_RUN, 8'h55, 7'd3);
    queue_cmd(CMD_PUT_RUN, 8'h01, 7'd127);
    queue_cmd(CMD_PUT_RUN, 8'h80, 7'd0);
    queue_cmd(CMD_PUT_RUN, 8'h11, 7'd2);
    queue_cmd(CMD_PUT, 8'h22, 7'd0);
    queue_cmd(CMD_PUT_RUN, 8'h33, 7'd127);
    queue_cmd(CMD_GET, 8'h00, 7'd0);
    queue_cmd(CMD_CLEAR, 8'h00, 7'd0);
    queue_cmd(CMD_GET, 8'h00, 7'd0);
    wait_drained();

    // Small capacity: a run that fills it exactly, then refusals.
    write_capacity(7'd3);
    queue_cmd(CMD_PUT_RUN, 8'h5A, 7'd3);
    queue_cmd(CMD_PUT_RUN, 8'hA5, 7'd0);
    queue_cmd(CMD_PUT_RUN, 8'h3C, 7'd0);
    queue_cmd(CMD_PUT, 8'hC3, 7'd0);
    queue_cmd(CMD_PUT_RUN, 8'h0F, 7'd1);
    queue_cmd(CMD_GET, 8'h00, 7'd0);
    queue_cmd(CMD_PUT_RUN, 8'hF0, 7'd1);
    wait_drained();

    // Random phases, each with a capacity write and one of three idle patterns.
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 48;
      end else if (p < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(phase_caps[p]);
      queue_random_ops(PHASE_ITEMS, (p % 2 == 0) ? 15 : 40);
      wait_drained();
    end

    repeat (5) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    $display("Covered %0d commands and %0d results over %0d capacity writes.",
             items_accepted, results_checked, cap_writes);
    $display("Seen %0d full and %0d empty answers, with %0d mismatches.",
             full_answers, empty_answers, mismatches);
    if (mismatches == 0) begin
      $display("tb_ring_buffer_fifo: done, clean");
    end else begin
      $display("tb_ring_buffer_fifo: done, errors");
    end
    $finish;
  end

endmodule
